// File: src/upe_pkg.sv
// ----------------------------------------------------------------------------
// upe_pkg: shared types and constants of the echo-pulse ranger
// Register indexes, reset values, status codes, the pipeline payload and
// the reciprocal used to scale echo width to sixteenths of a centimeter.
// ----------------------------------------------------------------------------
package upe_pkg;

  // widths of the fixed fields
  localparam int unsigned WIDTH_W    = 16;
  localparam int unsigned DIST_W     = 16;
  localparam int unsigned STALE_W    = 20;
  localparam int unsigned PULSE_W    = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // distance scaling: floor(width * 2^FRACTION_BITS / TICKS_PER_CM)
  localparam int unsigned TICKS_PER_CM  = 58;
  localparam int unsigned FRACTION_BITS = 4;
  localparam int unsigned SCALED_W      = WIDTH_W + FRACTION_BITS;
  localparam int unsigned DIV_SHIFT     = SCALED_W + $clog2(TICKS_PER_CM);
  localparam longint unsigned DIV_RECIP =
    ((64'd1 << DIV_SHIFT) + 64'(TICKS_PER_CM) - 64'd1) / 64'(TICKS_PER_CM);
  localparam int unsigned RECIP_W       = SCALED_W + 1;
  localparam int unsigned PROD_W        = SCALED_W + RECIP_W;
  localparam int unsigned QUOT_W        = PROD_W - DIV_SHIFT;

  // register reset values
  localparam logic [WIDTH_W-1:0] PING_INTERVAL_RST = 16'd50000;
  localparam logic [WIDTH_W-1:0] ECHO_TIMEOUT_RST  = 16'd40000;
  localparam logic [STALE_W-1:0] STALE_LIMIT_RST   = 20'd200000;
  localparam logic [PULSE_W-1:0] TRIGGER_PULSE_RST = 4'd10;
  localparam logic [WIDTH_W-1:0] MIN_WIDTH_RST     = 16'd116;
  localparam logic [WIDTH_W-1:0] MAX_WIDTH_RST     = 16'd23200;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PING_INTERVAL = 3'd0,
    CFG_ECHO_TIMEOUT  = 3'd1,
    CFG_STALE_LIMIT   = 3'd2,
    CFG_TRIGGER_PULSE = 3'd3,
    CFG_MIN_WIDTH     = 3'd4,
    CFG_MAX_WIDTH     = 3'd5
  } cfg_idx_e;

  // measurement status codes
  typedef enum logic [2:0] {
    ST_VALID     = 3'd0,
    ST_NO_RESULT = 3'd1,
    ST_NO_ECHO   = 3'd2,
    ST_STALE     = 3'd3,
    ST_RANGE     = 3'd4
  } status_e;

  // configuration register set
  typedef struct packed {
    logic [WIDTH_W-1:0] ping_interval;
    logic [WIDTH_W-1:0] echo_timeout;
    logic [STALE_W-1:0] stale_limit;
    logic [PULSE_W-1:0] trigger_pulse;
    logic [WIDTH_W-1:0] min_width;
    logic [WIDTH_W-1:0] max_width;
  } cfg_t;

  // payload between tracker and scaler
  typedef struct packed {
    logic               trigger;
    status_e            status;
    logic [WIDTH_W-1:0] width;
  } meas_t;

endpackage

// File: src/upe_cfg_regs.sv
// ----------------------------------------------------------------------------
// upe_cfg_regs: configuration register file
// Six registers written through an indexed write channel, masked to width.
// ----------------------------------------------------------------------------
module upe_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [upe_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [upe_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output upe_pkg::cfg_t                   cfg_o
);

  upe_pkg::cfg_t cfg_q;

  // writes are always taken
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ping_interval <= upe_pkg::PING_INTERVAL_RST;
      cfg_q.echo_timeout  <= upe_pkg::ECHO_TIMEOUT_RST;
      cfg_q.stale_limit   <= upe_pkg::STALE_LIMIT_RST;
      cfg_q.trigger_pulse <= upe_pkg::TRIGGER_PULSE_RST;
      cfg_q.min_width     <= upe_pkg::MIN_WIDTH_RST;
      cfg_q.max_width     <= upe_pkg::MAX_WIDTH_RST;
    end else if (cfg_valid_i) begin
      unique case (upe_pkg::cfg_idx_e'(cfg_index_i))
        upe_pkg::CFG_PING_INTERVAL: begin
          cfg_q.ping_interval <= cfg_data_i[upe_pkg::WIDTH_W-1:0];
        end
        upe_pkg::CFG_ECHO_TIMEOUT: begin
          cfg_q.echo_timeout <= cfg_data_i[upe_pkg::WIDTH_W-1:0];
        end
        upe_pkg::CFG_STALE_LIMIT: begin
          cfg_q.stale_limit <= cfg_data_i[upe_pkg::STALE_W-1:0];
        end
        upe_pkg::CFG_TRIGGER_PULSE: begin
          cfg_q.trigger_pulse <= cfg_data_i[upe_pkg::PULSE_W-1:0];
        end
        upe_pkg::CFG_MIN_WIDTH: begin
          cfg_q.min_width <= cfg_data_i[upe_pkg::WIDTH_W-1:0];
        end
        upe_pkg::CFG_MAX_WIDTH: begin
          cfg_q.max_width <= cfg_data_i[upe_pkg::WIDTH_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: src/upe_tracker.sv
// ----------------------------------------------------------------------------
// upe_tracker: per-tick ranging state and status
// Advances counters, handles echo edges, timeout and trigger on each accepted
// tick, and registers trigger level, status and stored width.
// ----------------------------------------------------------------------------
module upe_tracker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  upe_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          echo_level_i,
  input  logic          advance_i,
  output logic          meas_valid_o,
  output upe_pkg::meas_t meas_o
);

  localparam logic [upe_pkg::WIDTH_W-1:0] WIDTH_MAX = '1;
  localparam logic [upe_pkg::STALE_W-1:0] STALE_MAX = '1;

  logic [upe_pkg::WIDTH_W-1:0] since_trig_q, since_trig_d;
  logic [upe_pkg::STALE_W-1:0] since_res_q, since_res_d;
  logic [upe_pkg::WIDTH_W-1:0] width_cnt_q, width_cnt_d;
  logic [upe_pkg::WIDTH_W-1:0] stored_q, stored_d;
  logic [upe_pkg::PULSE_W-1:0] pulse_q, pulse_d;
  logic                        awaiting_q, awaiting_d;
  logic                        echo_hi_q, echo_hi_d;
  logic                        prev_q;
  logic                        have_q, have_d;
  logic                        meas_valid_q;
  upe_pkg::meas_t              meas_q, meas_d;
  upe_pkg::status_e            status_d;
  logic                        accept;

  // stage register frees up when the scaler takes it
  assign in_ready_o   = !meas_valid_q || advance_i;
  assign accept       = in_valid_i && in_ready_o;
  assign meas_valid_o = meas_valid_q;
  assign meas_o       = meas_q;

  // next state for one tick
  always_comb begin
    since_trig_d = (since_trig_q != WIDTH_MAX) ? since_trig_q + 1'b1 : since_trig_q;
    since_res_d  = (since_res_q != STALE_MAX) ? since_res_q + 1'b1 : since_res_q;
    width_cnt_d  = width_cnt_q;
    if (echo_hi_q && (width_cnt_q != WIDTH_MAX)) begin
      width_cnt_d = width_cnt_q + 1'b1;
    end
    pulse_d    = (pulse_q != '0) ? pulse_q - 1'b1 : pulse_q;
    stored_d   = stored_q;
    awaiting_d = awaiting_q;
    echo_hi_d  = echo_hi_q;
    have_d     = have_q;

    // echo edges while a measurement is open
    if (awaiting_q) begin
      if (echo_level_i && !prev_q) begin
        width_cnt_d = '0;
        echo_hi_d   = 1'b1;
      end else if (!echo_level_i && prev_q && echo_hi_q) begin
        stored_d    = width_cnt_d;
        have_d      = 1'b1;
        since_res_d = '0;
        echo_hi_d   = 1'b0;
        awaiting_d  = 1'b0;
      end
    end

    // timeout gives a no-echo result
    if (awaiting_d && (since_trig_d >= cfg_i.echo_timeout)) begin
      awaiting_d  = 1'b0;
      echo_hi_d   = 1'b0;
      stored_d    = '0;
      have_d      = 1'b1;
      since_res_d = '0;
    end

    // fire a new trigger pulse
    if (!awaiting_d && (since_trig_d >= cfg_i.ping_interval)) begin
      since_trig_d = '0;
      awaiting_d   = 1'b1;
      echo_hi_d    = 1'b0;
      pulse_d      = cfg_i.trigger_pulse;
    end
  end

  // status classification by priority
  always_comb begin
    priority if (!have_d) begin
      status_d = upe_pkg::ST_NO_RESULT;
    end else if (stored_d == '0) begin
      status_d = upe_pkg::ST_NO_ECHO;
    end else if (since_res_d > cfg_i.stale_limit) begin
      status_d = upe_pkg::ST_STALE;
    end else if ((stored_d < cfg_i.min_width) || (stored_d > cfg_i.max_width)) begin
      status_d = upe_pkg::ST_RANGE;
    end else begin
      status_d = upe_pkg::ST_VALID;
    end
    meas_d.trigger = (pulse_d != '0);
    meas_d.status  = status_d;
    meas_d.width   = stored_d;
  end

  // ranging state and stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      since_trig_q <= WIDTH_MAX;
      since_res_q  <= '0;
      width_cnt_q  <= '0;
      stored_q     <= '0;
      pulse_q      <= '0;
      awaiting_q   <= 1'b0;
      echo_hi_q    <= 1'b0;
      prev_q       <= 1'b0;
      have_q       <= 1'b0;
      meas_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        since_trig_q <= since_trig_d;
        since_res_q  <= since_res_d;
        width_cnt_q  <= width_cnt_d;
        stored_q     <= stored_d;
        pulse_q      <= pulse_d;
        awaiting_q   <= awaiting_d;
        echo_hi_q    <= echo_hi_d;
        prev_q       <= echo_level_i;
        have_q       <= have_d;
      end
      if (in_ready_o) begin
        meas_valid_q <= in_valid_i;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      meas_q <= meas_d;
    end
  end

endmodule

// File: src/upe_scaler.sv
// ----------------------------------------------------------------------------
// upe_scaler: width to distance conversion and result register
// Divides the scaled width by ticks per centimeter through a reciprocal
// multiply and holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module upe_scaler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          meas_valid_i,
  input  upe_pkg::meas_t                meas_i,
  output logic                          advance_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          trigger_level_o,
  output logic [2:0]                    status_o,
  output logic [upe_pkg::DIST_W-1:0]    distance_sixteenths_cm_o
);

  localparam int unsigned CMP_W = (upe_pkg::QUOT_W > upe_pkg::DIST_W) ?
                                  upe_pkg::QUOT_W : upe_pkg::DIST_W;
  localparam logic [upe_pkg::RECIP_W-1:0] RECIP = upe_pkg::RECIP_W'(upe_pkg::DIV_RECIP);
  localparam logic [CMP_W-1:0] DIST_MAX = CMP_W'({upe_pkg::DIST_W{1'b1}});

  logic [upe_pkg::SCALED_W-1:0] scaled;
  logic [upe_pkg::PROD_W-1:0]   product;
  logic [upe_pkg::QUOT_W-1:0]   quot;
  logic [upe_pkg::DIST_W-1:0]   dist_d, dist_q;
  logic                         out_valid_q;
  logic                         trigger_q;
  upe_pkg::status_e             status_q;

  // output register moves when empty or taken
  assign advance_o = !out_valid_q || out_ready_i;

  // reciprocal multiply, exact over the whole scaled range
  always_comb begin
    scaled  = upe_pkg::SCALED_W'(meas_i.width) << upe_pkg::FRACTION_BITS;
    product = upe_pkg::PROD_W'(scaled) * upe_pkg::PROD_W'(RECIP);
    quot    = product[upe_pkg::PROD_W-1:upe_pkg::DIV_SHIFT];
    if (meas_i.status != upe_pkg::ST_VALID) begin
      dist_d = '0;
    end else if (CMP_W'(quot) > DIST_MAX) begin
      dist_d = '1;
    end else begin
      dist_d = upe_pkg::DIST_W'(quot);
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance_o) begin
      out_valid_q <= meas_valid_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (advance_o && meas_valid_i) begin
      trigger_q <= meas_i.trigger;
      status_q  <= meas_i.status;
      dist_q    <= dist_d;
    end
  end

  assign out_valid_o              = out_valid_q;
  assign trigger_level_o          = trigger_q;
  assign status_o                 = status_q;
  assign distance_sixteenths_cm_o = dist_q;

endmodule

// File: src/ultrasonic_ping_echo_ranger.sv
// ----------------------------------------------------------------------------
// ultrasonic_ping_echo_ranger: ultrasonic echo-pulse range finder
// Fires trigger pulses and measures echo width in microsecond ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one microsecond tick with
//   the sampled echo pin level. Every tick transfer yields exactly one result
//   transfer on the output channel (out_valid_o/out_ready_i): trigger pin
//   level, status and distance in 1/16 cm.
//   The configuration channel writes register cfg_index_i with cfg_data_i;
//   it is always ready and is meant to be used while no tick is in flight.
//   Throughput: one tick per cycle while the receiver keeps up. Each tick
//   is registered with its state update and status in the first stage,
//   then with the reciprocal multiply for the distance in the second stage.
//   When the receiver stalls, the output register holds its result, the
//   first stage holds one more, and in_ready_o drops while both are full.
//   Reset loads the register defaults, clears all results, and arms the
//   ranging state so the first tick fires a trigger pulse.
// ----------------------------------------------------------------------------
module ultrasonic_ping_echo_ranger (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [upe_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [upe_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            echo_level_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            trigger_level_o,
  output logic [2:0]                      status_o,
  output logic [upe_pkg::DIST_W-1:0]      distance_sixteenths_cm_o
);

  upe_pkg::cfg_t  cfg;
  upe_pkg::meas_t meas;
  logic           meas_valid;
  logic           advance;

  // configuration registers
  upe_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // ranging state and status stage
  upe_tracker u_tracker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .echo_level_i (echo_level_i),
    .advance_i    (advance),
    .meas_valid_o (meas_valid),
    .meas_o       (meas)
  );

  // distance stage and result register
  upe_scaler u_scaler (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .meas_valid_i             (meas_valid),
    .meas_i                   (meas),
    .advance_o                (advance),
    .out_valid_o              (out_valid_o),
    .out_ready_i              (out_ready_i),
    .trigger_level_o          (trigger_level_o),
    .status_o                 (status_o),
    .distance_sixteenths_cm_o (distance_sixteenths_cm_o)
  );

  // distance is zero unless the measurement is valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != upe_pkg::ST_VALID) |-> distance_sixteenths_cm_o == '0)
    else $error("distance set on a non-valid status");

  // a tick transfer always lands in the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> meas_valid)
    else $error("accepted tick lost before the first stage");

  // both stages full and a stalled receiver block new ticks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && meas_valid |-> !in_ready_o)
    else $error("tick accepted while the pipeline is full");

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the ultrasonic echo-pulse ranger
// Streams echo-level ticks into the ranger and predicts every tick's trigger
// level, status and distance with a behavioral copy of the ranging state.
// Each result transfer is checked in order. Configuration is rewritten between
// phases, with extreme settings among them, while the ranger is quiet.
// ----------------------------------------------------------------------------
module testbench;

  // unused register slots past the last defined register
  localparam logic [upe_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [upe_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam int unsigned RAND_PHASES    = 12;
  localparam int unsigned PHASE_TICKS    = 110;
  localparam int unsigned WIDE_TICKS     = 60;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned HOLD_AT_RESULT = 1000;
  localparam int unsigned HOLD_CYCLES    = 48;
  localparam int unsigned MAX_REPORTS    = 200;

  // config picks for a phase
  localparam int PICK_RANDOM = 0;
  localparam int PICK_LOW    = 1;
  localparam int PICK_HIGH   = 2;

  typedef struct packed {
    logic                       trigger;
    upe_pkg::status_e           status;
    logic [upe_pkg::DIST_W-1:0] distance;
  } range_result_t;

  logic                           clk_i        = 1'b0;
  logic                           rst_ni       = 1'b0;
  logic                           cfg_valid_i  = 1'b0;
  logic                           cfg_ready_o;
  logic [upe_pkg::CFG_IDX_W-1:0]  cfg_index_i  = '0;
  logic [upe_pkg::CFG_DATA_W-1:0] cfg_data_i   = '0;
  logic                           in_valid_i   = 1'b0;
  logic                           in_ready_o;
  logic                           echo_level_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_ready_i  = 1'b0;
  logic                           trigger_level_o;
  logic [2:0]                     status_o;
  logic [upe_pkg::DIST_W-1:0]     distance_sixteenths_cm_o;

  // stimulus and expectations
  logic          echo_ticks_q[$];
  range_result_t range_results_q[$];

  int unsigned send_idle_pct = 9;
  int unsigned recv_idle_pct = 75;
  int unsigned mismatches    = 0;
  int unsigned results_seen  = 0;
  int unsigned hold_left     = 0;
  logic        hold_done     = 1'b0;
  int unsigned stall_cycles  = 0;
  range_result_t want_res, got_res;

  // predicted register set
  logic [upe_pkg::WIDTH_W-1:0] ping_reg, timeout_reg, min_reg, max_reg;
  logic [upe_pkg::STALE_W-1:0] stale_reg;
  logic [upe_pkg::PULSE_W-1:0] pulse_reg;

  // predicted ranging state
  logic [upe_pkg::WIDTH_W-1:0] since_trigger, width_count, held_width;
  logic [upe_pkg::STALE_W-1:0] since_result;
  logic [upe_pkg::PULSE_W-1:0] pulse_left;
  logic                        awaiting, echo_high, prev_level, got_result;

  ultrasonic_ping_echo_ranger u_dut (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .cfg_valid_i              (cfg_valid_i),
    .cfg_ready_o              (cfg_ready_o),
    .cfg_index_i              (cfg_index_i),
    .cfg_data_i               (cfg_data_i),
    .in_valid_i               (in_valid_i),
    .in_ready_o               (in_ready_o),
    .echo_level_i             (echo_level_i),
    .out_valid_o              (out_valid_o),
    .out_ready_i              (out_ready_i),
    .trigger_level_o          (trigger_level_o),
    .status_o                 (status_o),
    .distance_sixteenths_cm_o (distance_sixteenths_cm_o)
  );

  always #4 clk_i = ~clk_i;

  task automatic reset_ranging_state();
    ping_reg      = upe_pkg::PING_INTERVAL_RST;
    timeout_reg   = upe_pkg::ECHO_TIMEOUT_RST;
    stale_reg     = upe_pkg::STALE_LIMIT_RST;
    pulse_reg     = upe_pkg::TRIGGER_PULSE_RST;
    min_reg       = upe_pkg::MIN_WIDTH_RST;
    max_reg       = upe_pkg::MAX_WIDTH_RST;
    since_trigger = '1;
    since_result  = '0;
    width_count   = '0;
    held_width    = '0;
    pulse_left    = '0;
    awaiting      = 1'b0;
    echo_high     = 1'b0;
    prev_level    = 1'b0;
    got_result    = 1'b0;
  endtask

  // advance the ranging state by one tick and form its result
  function automatic range_result_t predict_range_result(input logic level);
    range_result_t r;
    int unsigned   q;
    // free-running counters
    if (since_trigger != '1) since_trigger++;
    if (since_result != '1) since_result++;
    if (echo_high && width_count != '1) width_count++;
    if (pulse_left != 0) pulse_left--;
    // echo edges only count while a measurement is open
    if (awaiting) begin
      if (level && !prev_level) begin
        width_count = '0;
        echo_high   = 1'b1;
      end else if (!level && prev_level && echo_high) begin
        held_width   = width_count;
        got_result   = 1'b1;
        since_result = '0;
        echo_high    = 1'b0;
        awaiting     = 1'b0;
      end
    end
    prev_level = level;
    // give up on a late echo
    if (awaiting && since_trigger >= timeout_reg) begin
      awaiting     = 1'b0;
      echo_high    = 1'b0;
      held_width   = '0;
      got_result   = 1'b1;
      since_result = '0;
    end
    // fire the next ping
    if (!awaiting && since_trigger >= ping_reg) begin
      since_trigger = '0;
      awaiting      = 1'b1;
      echo_high     = 1'b0;
      pulse_left    = pulse_reg;
    end
    // status in priority order
    r.distance = '0;
    if (!got_result) begin
      r.status = upe_pkg::ST_NO_RESULT;
    end else if (held_width == 0) begin
      r.status = upe_pkg::ST_NO_ECHO;
    end else if (since_result > stale_reg) begin
      r.status = upe_pkg::ST_STALE;
    end else if (held_width < min_reg || held_width > max_reg) begin
      r.status = upe_pkg::ST_RANGE;
    end else begin
      r.status   = upe_pkg::ST_VALID;
      q          = (32'(held_width) << upe_pkg::FRACTION_BITS) / upe_pkg::TICKS_PER_CM;
      r.distance = (q > 32'hFFFF) ? '1 : upe_pkg::DIST_W'(q);
    end
    r.trigger = (pulse_left != 0);
    return r;
  endfunction

  // tick driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      echo_level_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o)
        range_results_q.push_back(predict_range_result(echo_level_i));
      if (!in_valid_i || in_ready_o) begin
        if (echo_ticks_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i   <= 1'b1;
          echo_level_i <= echo_ticks_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure and one long hold
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        got_res.trigger  = trigger_level_o;
        got_res.status   = upe_pkg::status_e'(status_o);
        got_res.distance = distance_sixteenths_cm_o;
        if (range_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, got trigger %0b status %0d dist %0d",
                     $time, got_res.trigger, got_res.status, got_res.distance);
        end else begin
          want_res = range_results_q.pop_front();
          if (got_res.trigger !== want_res.trigger || got_res.status !== want_res.status ||
              got_res.distance !== want_res.distance) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: expected trigger %0b status %0d dist %0d, got trigger %0b %s",
                       $time, want_res.trigger, want_res.status, want_res.distance,
                       got_res.trigger,
                       $sformatf("status %0d dist %0d", got_res.status, got_res.distance));
          end
        end
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left   <= hold_left - 1;
      end else if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
        out_ready_i <= 1'b0;
        hold_left   <= HOLD_CYCLES;
        hold_done   <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic apply_reg(input logic [upe_pkg::CFG_IDX_W-1:0] idx,
                           input logic [upe_pkg::CFG_DATA_W-1:0] data);
    unique case (idx)
      upe_pkg::CFG_PING_INTERVAL: ping_reg    = data[upe_pkg::WIDTH_W-1:0];
      upe_pkg::CFG_ECHO_TIMEOUT:  timeout_reg = data[upe_pkg::WIDTH_W-1:0];
      upe_pkg::CFG_STALE_LIMIT:   stale_reg   = data[upe_pkg::STALE_W-1:0];
      upe_pkg::CFG_TRIGGER_PULSE: pulse_reg   = data[upe_pkg::PULSE_W-1:0];
      upe_pkg::CFG_MIN_WIDTH:     min_reg     = data[upe_pkg::WIDTH_W-1:0];
      upe_pkg::CFG_MAX_WIDTH:     max_reg     = data[upe_pkg::WIDTH_W-1:0];
      default: ;
    endcase
  endtask

  // valid is left high so back-to-back writes stay on one level
  task automatic write_reg(input logic [upe_pkg::CFG_IDX_W-1:0] idx,
                           input logic [upe_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, data);
  endtask

  // full register set, with junk in the bits above each field
  task automatic set_ranges(input int unsigned ping, timeout, stale, pulse, min_w, max_w);
    logic [upe_pkg::CFG_DATA_W-1:0] junk;
    junk = upe_pkg::CFG_DATA_W'($urandom);
    write_reg(upe_pkg::CFG_PING_INTERVAL, {junk[19:16], 16'(ping)});
    write_reg(upe_pkg::CFG_ECHO_TIMEOUT, {~junk[19:16], 16'(timeout)});
    write_reg(upe_pkg::CFG_STALE_LIMIT, 20'(stale));
    write_reg(upe_pkg::CFG_TRIGGER_PULSE, {junk[19:4], 4'(pulse)});
    write_reg(upe_pkg::CFG_MIN_WIDTH, {junk[17:14], 16'(min_w)});
    write_reg(upe_pkg::CFG_MAX_WIDTH, {~junk[17:14], 16'(max_w)});
    write_reg(CFG_SPARE_LO, junk);
    write_reg(CFG_SPARE_HI, ~junk);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int unsigned rand_setting(input int pick,
                                               input int unsigned lo, hi, usual_hi);
    if (pick == PICK_LOW) return lo;
    if (pick == PICK_HIGH) return hi;
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? hi : lo;
    return $urandom_range(lo, usual_hi);
  endfunction

  task automatic queue_pattern(input logic [15:0] bits, input int unsigned n);
    for (int i = n - 1; i >= 0; i--) echo_ticks_q.push_back(bits[i]);
  endtask

  // mostly clean low/high runs scaled to the timeout, with short noise bursts
  task automatic queue_echo_train(input int unsigned count);
    int unsigned span, run;
    logic        level;
    level = 1'b0;
    span  = ((timeout_reg < 40) ? timeout_reg : 40) + 2;
    while (count != 0) begin
      if ($urandom_range(0, 5) == 0) begin
        run = $urandom_range(1, 6);
        while (run != 0 && count != 0) begin
          echo_ticks_q.push_back(1'($urandom));
          run--;
          count--;
        end
      end else begin
        run = level ? $urandom_range(1, span) : $urandom_range(0, span);
        while (run != 0 && count != 0) begin
          echo_ticks_q.push_back(level);
          run--;
          count--;
        end
        level = ~level;
      end
    end
  endtask

  // quiet means nothing queued, offered or outstanding over as many clocks in a row as asked
  task automatic wait_quiet(input int unsigned cycles);
    int unsigned quiet;
    quiet = 0;
    while (quiet < cycles) begin
      @(posedge clk_i);
      if (echo_ticks_q.size() != 0 || in_valid_i || range_results_q.size() != 0)
        quiet = 0;
      else
        quiet++;
    end
  endtask

  // sequence of phases
  initial begin
    int pick;
    reset_ranging_state();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: immediate ping, short echo out of range, edges while idle
    queue_pattern(16'b0111_0010_1100, 12);
    wait_quiet(SETTLE_CYCLES);
    // echo already high at the ping, timeout, retrigger inside a long pulse
    set_ranges(3, 1, 2, 15, 0, 65535);
    queue_pattern(16'b1110_1001, 8);
    wait_quiet(SETTLE_CYCLES);
    // no trigger pulse, inverted width window, quick staleness
    set_ranges(4, 8, 1, 0, 2, 1);
    queue_pattern(16'b0111_0000, 8);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_quiet(SETTLE_CYCLES);
      if (ph < 4) begin
        send_idle_pct = 9;
        recv_idle_pct = 75;
      end else if (ph < 8) begin
        send_idle_pct = 75;
        recv_idle_pct = 9;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      pick = (ph == 3) ? PICK_LOW : (ph == 7) ? PICK_HIGH : PICK_RANDOM;
      set_ranges(rand_setting(pick, 1, 65535, 40), rand_setting(pick, 1, 65535, 40),
                 rand_setting(pick, 1, 1048575, 80), rand_setting(pick, 0, 15, 15),
                 rand_setting(pick, 0, 65535, 24), rand_setting(pick, 0, 65535, 40));
      queue_echo_train((pick == PICK_HIGH) ? WIDE_TICKS : PHASE_TICKS);
    end

    wait_quiet(DRAIN_CYCLES);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
